// ----- rtl/pdd_pkg.sv -----
package pdd_pkg;

   // Field widths of one vertex and of the distance threshold.
   localparam int LAT_W = 28;
   localparam int LON_W = 29;
   localparam int THR_W = 58;

   // Squared difference widths: a latitude difference stays below 2^28 in
   // magnitude and a longitude difference below 2^29.
   localparam int LAT_SQ_W = 2 * LAT_W;
   localparam int LON_SQ_W = 2 * LON_W;
   localparam int DIST_W   = LON_SQ_W + 1;

   // Most results that one item can cause.
   localparam int MAX_PUSH = 3;
   localparam int PUSH_W   = 2;

   // One result item as it sits in the output queue.
   typedef struct packed {
      logic signed [LAT_W-1:0] out_lat;
      logic signed [LON_W-1:0] out_lon;
      logic                    polygon_end;
      logic                    run_last;
   } rsp_item_type;

endpackage

// ----- rtl/pdd_sq_dist.sv -----
module pdd_sq_dist (
   input  logic signed [pdd_pkg::LAT_W-1:0]    a_lat,
   input  logic signed [pdd_pkg::LON_W-1:0]    a_lon,
   input  logic signed [pdd_pkg::LAT_W-1:0]    b_lat,
   input  logic signed [pdd_pkg::LON_W-1:0]    b_lon,
   output logic        [pdd_pkg::LAT_SQ_W-1:0] lat_sq,
   output logic        [pdd_pkg::LON_SQ_W-1:0] lon_sq
);
   import pdd_pkg::*;

   logic signed [LAT_W:0]       lat_diff;
   logic signed [LON_W:0]       lon_diff;
   logic signed [2*LAT_W+1:0]   lat_prod;
   logic signed [2*LON_W+1:0]   lon_prod;

   // Exact differences, one bit wider than the coordinates.
   assign lat_diff = {a_lat[LAT_W-1], a_lat} - {b_lat[LAT_W-1], b_lat};
   assign lon_diff = {a_lon[LON_W-1], a_lon} - {b_lon[LON_W-1], b_lon};

   // Squares are never negative and fit the narrower result exactly.
   assign lat_prod = lat_diff * lat_diff;
   assign lon_prod = lon_diff * lon_diff;
   assign lat_sq   = lat_prod[LAT_SQ_W-1:0];
   assign lon_sq   = lon_prod[LON_SQ_W-1:0];

endmodule

// ----- rtl/pdd_rsp_queue.sv -----
module pdd_rsp_queue #(
   parameter int DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pdd_pkg::PUSH_W-1:0]    push_count,
   input  pdd_pkg::rsp_item_type         push_items [pdd_pkg::MAX_PUSH],
   output logic                          room,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pdd_pkg::rsp_item_type         rsp_item
);
   import pdd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type          entries [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PTR_W-1:0]      wr_idx [MAX_PUSH+1];
   logic                  pop;

   // Write positions for each pushed item, wrapped at the depth.
   always_comb begin
      logic [PTR_W+1:0] sum;
      for (int k = 0; k <= MAX_PUSH; k++) begin
         sum = (PTR_W+2)'(wr_ptr_ff) + (PTR_W+2)'(k);
         if (sum >= (PTR_W+2)'(DEPTH)) begin
            sum = sum - (PTR_W+2)'(DEPTH);
         end
         wr_idx[k] = sum[PTR_W-1:0];
      end
   end

   // Pointer and fill count bookkeeping.
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_in = wr_idx[push_count];
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for queued items; up to three are written per cycle.
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PUSH; k++) begin
         if (PUSH_W'(k) < push_count) begin
            entries[wr_idx[k]] <= push_items[k];
         end
      end
   end

   // The head item drives the result channel.
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entries[rd_ptr_ff];
   assign room      = (count_ff <= CNT_W'(DEPTH - MAX_PUSH));

   // The queue never holds more items than it has entries.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   // Items are only pushed when three free entries were reported.
   assert property (@(posedge clock) disable iff (reset)
      (push_count != '0) |-> (count_ff <= CNT_W'(DEPTH - MAX_PUSH)))
      else $error("items pushed without room");

   // A stalled head item holds still until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed");

endmodule

// ----- rtl/polyline_distance_decimator_core.sv -----
// Polyline distance decimator.
// Input channel req_*: one polygon vertex per item (latitude, longitude in
// micro-degrees, and a flag on the last vertex of each polygon). An item is
// taken at a clock edge where req_valid is high and req_stall is low.
// Result channel rsp_*: kept vertices, one per item, with polygon_end on the
// closing vertex of a polygon and run_last on the last result of an input item.
// The csr_* port writes the squared distance threshold; write it only while idle.
// An item passes an input stage and a decision stage and lands in the output
// queue, from whose head its results are taken.
// Throughput: one input item per cycle while the queue has room. The output
// queue drains one result per cycle unless the receiver stalls, so a polygon
// close that yields three results can hold the input. The decision stage
// needs three free queue entries to proceed. When the receiver stalls, the queue
// fills and the decision stage waits once fewer than three entries are free;
// req_stall rises when the input stage then holds an item. Nothing is dropped.
// Reset clears the threshold, the pipeline, the queue and the open-polygon flag.
module polyline_distance_decimator_core #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [pdd_pkg::LAT_W-1:0]  req_point_lat,
   input  logic signed [pdd_pkg::LON_W-1:0]  req_point_lon,
   input  logic                              req_polygon_last,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pdd_pkg::LAT_W-1:0]  rsp_out_lat,
   output logic signed [pdd_pkg::LON_W-1:0]  rsp_out_lon,
   output logic                              rsp_polygon_end,
   output logic                              rsp_run_last,
   // Threshold register
   input  logic                              csr_wr_en,
   input  logic [pdd_pkg::THR_W-1:0]         csr_wr_data
);
   import pdd_pkg::*;

   logic [THR_W-1:0]        thr_ff;

   // Input stage.
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [LAT_W-1:0] s1_lat_ff;
   logic signed [LON_W-1:0] s1_lon_ff;
   logic                    s1_last_ff;
   logic                    req_accept;
   logic                    s1_move;

   // Decision stage.
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [LAT_W-1:0] s2_lat_ff;
   logic signed [LON_W-1:0] s2_lon_ff;
   logic                    s2_last_ff;
   logic [LAT_SQ_W-1:0]     s2_sqa_lat_ff, s2_sqb_lat_ff;
   logic [LON_SQ_W-1:0]     s2_sqa_lon_ff, s2_sqb_lon_ff;
   logic                    s2_selb_ff, s2_selb_in;
   logic                    s2_fire;

   // Polygon state.
   logic                    in_polygon_ff, in_polygon_in;
   logic signed [LAT_W-1:0] first_lat_ff, first_lat_in;
   logic signed [LON_W-1:0] first_lon_ff, first_lon_in;
   logic signed [LAT_W-1:0] pending_lat_ff, pending_lat_in;
   logic signed [LON_W-1:0] pending_lon_ff, pending_lon_in;

   // Distance candidates and the keep decision.
   logic [LAT_SQ_W-1:0]     sqa_lat, sqb_lat, sel_lat_sq;
   logic [LON_SQ_W-1:0]     sqa_lon, sqb_lon, sel_lon_sq;
   logic [DIST_W-1:0]       dist_sum;
   logic                    keep;

   // Queue interface.
   rsp_item_type            push_items [MAX_PUSH];
   logic [PUSH_W-1:0]       push_count;
   logic                    queue_room;
   rsp_item_type            head_item;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Handshake between the stages. The decision stage fires when the queue
   // can take every result an item may cause.
   assign s2_fire     = s2_valid_ff && queue_room;
   assign s1_move     = !s2_valid_ff || s2_fire;
   assign req_stall   = s1_valid_ff && !s1_move;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_lat_ff  <= req_point_lat;
         s1_lon_ff  <= req_point_lon;
         s1_last_ff <= req_polygon_last;
      end
   end

   // Squared distances against the two possible last kept vertices: the one
   // held now, and the vertex in the decision stage if it gets kept this cycle.
   pdd_sq_dist u_sq_hold (
      .a_lat  (s1_lat_ff),
      .a_lon  (s1_lon_ff),
      .b_lat  (pending_lat_ff),
      .b_lon  (pending_lon_ff),
      .lat_sq (sqa_lat),
      .lon_sq (sqa_lon)
   );

   pdd_sq_dist u_sq_next (
      .a_lat  (s1_lat_ff),
      .a_lon  (s1_lon_ff),
      .b_lat  (s2_lat_ff),
      .b_lon  (s2_lon_ff),
      .lat_sq (sqb_lat),
      .lon_sq (sqb_lon)
   );

   // The second candidate applies when the item ahead replaces the kept vertex.
   assign s2_selb_in = s2_fire && (!in_polygon_ff || keep);

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         s2_lat_ff     <= s1_lat_ff;
         s2_lon_ff     <= s1_lon_ff;
         s2_last_ff    <= s1_last_ff;
         s2_sqa_lat_ff <= sqa_lat;
         s2_sqa_lon_ff <= sqa_lon;
         s2_sqb_lat_ff <= sqb_lat;
         s2_sqb_lon_ff <= sqb_lon;
         s2_selb_ff    <= s2_selb_in;
      end
   end

   // Keep decision: the distance must strictly exceed the threshold.
   assign sel_lat_sq = s2_selb_ff ? s2_sqb_lat_ff : s2_sqa_lat_ff;
   assign sel_lon_sq = s2_selb_ff ? s2_sqb_lon_ff : s2_sqa_lon_ff;
   assign dist_sum   = DIST_W'(sel_lat_sq) + DIST_W'(sel_lon_sq);
   assign keep       = dist_sum > DIST_W'(thr_ff);

   // Result list and next polygon state for the item in the decision stage.
   always_comb begin
      logic [PUSH_W-1:0] n;
      n              = '0;
      for (int k = 0; k < MAX_PUSH; k++) begin
         push_items[k] = '0;
      end
      first_lat_in   = first_lat_ff;
      first_lon_in   = first_lon_ff;
      pending_lat_in = pending_lat_ff;
      pending_lon_in = pending_lon_ff;
      in_polygon_in  = in_polygon_ff;
      if (!in_polygon_ff) begin
         // First vertex of a polygon is always kept.
         first_lat_in   = s2_lat_ff;
         first_lon_in   = s2_lon_ff;
         pending_lat_in = s2_lat_ff;
         pending_lon_in = s2_lon_ff;
         if (s2_last_ff) begin
            push_items[n] = '{s2_lat_ff, s2_lon_ff, 1'b1, 1'b0};
            n             = n + 2'd1;
         end else begin
            in_polygon_in = 1'b1;
         end
      end else begin
         // A kept vertex releases the previous one.
         if (keep) begin
            push_items[n]  = '{pending_lat_ff, pending_lon_ff, 1'b0, 1'b0};
            n              = n + 2'd1;
            pending_lat_in = s2_lat_ff;
            pending_lon_in = s2_lon_ff;
         end
         // Polygon close: flush the held vertex and close the ring if needed.
         if (s2_last_ff) begin
            if (pending_lat_in != first_lat_ff || pending_lon_in != first_lon_ff) begin
               push_items[n]         = '{pending_lat_in, pending_lon_in, 1'b0, 1'b0};
               push_items[n + 2'd1]  = '{first_lat_ff, first_lon_ff, 1'b1, 1'b0};
               n                     = n + 2'd2;
            end else begin
               push_items[n] = '{pending_lat_in, pending_lon_in, 1'b1, 1'b0};
               n             = n + 2'd1;
            end
            in_polygon_in = 1'b0;
         end
      end
      if (n != '0) begin
         push_items[n - 2'd1].run_last = 1'b1;
      end
      push_count = s2_fire ? n : '0;
   end

   // Polygon state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_polygon_ff <= 1'b0;
      end else if (s2_fire) begin
         in_polygon_ff <= in_polygon_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         first_lat_ff   <= first_lat_in;
         first_lon_ff   <= first_lon_in;
         pending_lat_ff <= pending_lat_in;
         pending_lon_ff <= pending_lon_in;
      end
   end

   // Output queue.
   pdd_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_items (push_items),
      .room       (queue_room),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (head_item)
   );

   assign rsp_out_lat     = head_item.out_lat;
   assign rsp_out_lon     = head_item.out_lon;
   assign rsp_polygon_end = head_item.polygon_end;
   assign rsp_run_last    = head_item.run_last;

   // A processed last vertex always leaves no polygon open.
   assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_last_ff) |=> !in_polygon_ff)
      else $error("polygon still open after its last vertex");

   // An opening vertex that is not last leaves a polygon open with no result.
   assert property (@(posedge clock) disable iff (reset)
      (s2_fire && !in_polygon_ff && !s2_last_ff) |-> (push_count == '0) ##1 in_polygon_ff)
      else $error("opening vertex handled wrongly");

   // An item leaving the input stage always arrives in the decision stage.
   assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_valid_ff) |=> s2_valid_ff)
      else $error("item lost between stages");

   // A last vertex always causes at least one result.
   assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_last_ff) |-> (push_count != '0))
      else $error("polygon end without result");

endmodule

// ----- sim/pdd_ring_checker.sv -----
module pdd_ring_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [pdd_pkg::LAT_W-1:0]  req_point_lat,
   input  logic signed [pdd_pkg::LON_W-1:0]  req_point_lon,
   input  logic                              req_polygon_last,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [pdd_pkg::LAT_W-1:0]  rsp_out_lat,
   input  logic signed [pdd_pkg::LON_W-1:0]  rsp_out_lon,
   input  logic                              rsp_polygon_end,
   input  logic                              rsp_run_last,
   input  logic                              csr_wr_en,
   input  logic [pdd_pkg::THR_W-1:0]         csr_wr_data,
   output int                                fail_count,
   output int                                expected_left
);

   // Keep the log readable when the block is badly broken.
   localparam int REPORT_CAP = 200;

   // Vertices still owed by the block, oldest first.
   pdd_pkg::rsp_item_type kept_vertex_q[$];
   pdd_pkg::rsp_item_type emitted [pdd_pkg::MAX_PUSH];
   pdd_pkg::rsp_item_type want;
   int                    n_out;

   // Shadow of the threshold register and of the open polygon.
   logic [pdd_pkg::THR_W-1:0]        gap_limit;
   logic signed [pdd_pkg::LAT_W-1:0] first_lat, held_lat;
   logic signed [pdd_pkg::LON_W-1:0] first_lon, held_lon;
   logic                             ring_open;
   logic [63:0]                      gap_sq;
   logic                             bad;
   int                               errors = 0;

   // Exact squared difference of two coordinates.
   function automatic logic [63:0] sq_gap(input longint a, input longint b);
      longint d;
      d = a - b;
      if (d < 0) begin
         d = -d;
      end
      return d * d;
   endfunction

   function automatic pdd_pkg::rsp_item_type make_vertex(
      input logic signed [pdd_pkg::LAT_W-1:0] lat,
      input logic signed [pdd_pkg::LON_W-1:0] lon,
      input logic                             ring_end
   );
      pdd_pkg::rsp_item_type v;
      v.out_lat     = lat;
      v.out_lon     = lon;
      v.polygon_end = ring_end;
      v.run_last    = 1'b0;
      return v;
   endfunction

   task automatic report_field(input string name, input longint exp_v, input longint got_v);
      bad = 1'b1;
      if (errors < REPORT_CAP) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kept_vertex_q.delete();
         gap_limit = '0;
         first_lat = '0;
         first_lon = '0;
         held_lat  = '0;
         held_lon  = '0;
         ring_open = 1'b0;
      end else begin
         // Compare an accepted result with the oldest owed vertex.
         if (rsp_valid && !rsp_stall) begin
            if (kept_vertex_q.size() == 0) begin
               if (errors < REPORT_CAP) begin
                  $display("%0t: unexpected result, expected none, got lat %0d lon %0d end %0b last %0b",
                           $time, rsp_out_lat, rsp_out_lon, rsp_polygon_end, rsp_run_last);
               end
               errors++;
            end else begin
               want = kept_vertex_q.pop_front();
               bad  = 1'b0;
               if (rsp_out_lat !== want.out_lat) begin
                  report_field("out_lat", longint'(want.out_lat), longint'(rsp_out_lat));
               end
               if (rsp_out_lon !== want.out_lon) begin
                  report_field("out_lon", longint'(want.out_lon), longint'(rsp_out_lon));
               end
               if (rsp_polygon_end !== want.polygon_end) begin
                  report_field("polygon_end", longint'(want.polygon_end),
                               longint'(rsp_polygon_end));
               end
               if (rsp_run_last !== want.run_last) begin
                  report_field("run_last", longint'(want.run_last), longint'(rsp_run_last));
               end
               if (bad) begin
                  errors++;
               end
            end
         end

         if (csr_wr_en) begin
            gap_limit = csr_wr_data;
         end

         // Work out which vertices an accepted item releases.
         if (req_valid && !req_stall) begin
            n_out = 0;
            if (!ring_open) begin
               first_lat = req_point_lat;
               first_lon = req_point_lon;
               held_lat  = req_point_lat;
               held_lon  = req_point_lon;
               if (req_polygon_last) begin
                  emitted[n_out] = make_vertex(req_point_lat, req_point_lon, 1'b1);
                  n_out++;
               end else begin
                  ring_open = 1'b1;
               end
            end else begin
               gap_sq = sq_gap(longint'(req_point_lat), longint'(held_lat))
                      + sq_gap(longint'(req_point_lon), longint'(held_lon));
               // The held vertex goes out once a far enough successor shows up.
               if (gap_sq > {6'd0, gap_limit}) begin
                  emitted[n_out] = make_vertex(held_lat, held_lon, 1'b0);
                  n_out++;
                  held_lat = req_point_lat;
                  held_lon = req_point_lon;
               end
               // Close the ring, repeating the first vertex unless it is the held one.
               if (req_polygon_last) begin
                  if (held_lat != first_lat || held_lon != first_lon) begin
                     emitted[n_out] = make_vertex(held_lat, held_lon, 1'b0);
                     n_out++;
                     emitted[n_out] = make_vertex(first_lat, first_lon, 1'b1);
                     n_out++;
                  end else begin
                     emitted[n_out] = make_vertex(held_lat, held_lon, 1'b1);
                     n_out++;
                  end
                  ring_open = 1'b0;
               end
            end
            for (int k = 0; k < n_out; k++) begin
               want = emitted[k];
               want.run_last = (k == n_out - 1);
               kept_vertex_q.insert(kept_vertex_q.size(), want);
            end
         end
      end
      fail_count    <= errors;
      expected_left <= kept_vertex_q.size();
   end

endmodule

// ----- sim/tb.sv -----
module tb;

   localparam int LAT_W = pdd_pkg::LAT_W;
   localparam int LON_W = pdd_pkg::LON_W;
   localparam int THR_W = pdd_pkg::THR_W;

   // Bit-pattern extremes of the coordinate fields.
   localparam logic signed [LAT_W-1:0] LAT_TOP = {1'b0, {(LAT_W-1){1'b1}}};
   localparam logic signed [LAT_W-1:0] LAT_BOT = {1'b1, {(LAT_W-1){1'b0}}};
   localparam logic signed [LON_W-1:0] LON_TOP = {1'b0, {(LON_W-1){1'b1}}};
   localparam logic signed [LON_W-1:0] LON_BOT = {1'b1, {(LON_W-1){1'b0}}};

   localparam int IDLE_PCT      = 15;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 86;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic signed [LAT_W-1:0] req_point_lat    = '0;
   logic signed [LON_W-1:0] req_point_lon    = '0;
   logic                    req_polygon_last = 1'b0;
   logic                    rsp_stall        = 1'b0;
   logic                    csr_wr_en        = 1'b0;
   logic [THR_W-1:0]        csr_wr_data      = '0;
   logic                    calm             = 1'b0;

   logic                    req_stall;
   logic                    rsp_valid;
   logic signed [LAT_W-1:0] rsp_out_lat;
   logic signed [LON_W-1:0] rsp_out_lon;
   logic                    rsp_polygon_end;
   logic                    rsp_run_last;

   int fail_count;
   int expected_left;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   polyline_distance_decimator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_lat    (req_point_lat),
      .req_point_lon    (req_point_lon),
      .req_polygon_last (req_polygon_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_lat      (rsp_out_lat),
      .rsp_out_lon      (rsp_out_lon),
      .rsp_polygon_end  (rsp_polygon_end),
      .rsp_run_last     (rsp_run_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   pdd_ring_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_lat    (req_point_lat),
      .req_point_lon    (req_point_lon),
      .req_polygon_last (req_polygon_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_lat      (rsp_out_lat),
      .rsp_out_lon      (rsp_out_lon),
      .rsp_polygon_end  (rsp_polygon_end),
      .rsp_run_last     (rsp_run_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .expected_left    (expected_left)
   );

   // Receiver stalls at random, except during the calm phase.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // Watchdog on cycles in which no item moves on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one vertex, with an occasional gap first, and wait until it is taken.
   task automatic send_vertex(
      input logic signed [LAT_W-1:0] lat,
      input logic signed [LON_W-1:0] lon,
      input logic                    last
   );
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_point_lat    <= lat;
      req_point_lon    <= lon;
      req_polygon_last <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off the sender until every owed vertex is out and the pipeline is empty.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random polygons as random walks of the given step size, mixed with stray vertices.
   task automatic walk_polygons(input int count, input int span);
      logic signed [LAT_W-1:0] lat, lat0;
      logic signed [LON_W-1:0] lon, lon0;
      int                      sides;
      int                      left;
      left = count;
      while (left > 0) begin
         if ($urandom_range(99) < 8) begin
            send_vertex(LAT_W'($urandom), LON_W'($urandom), 1'($urandom_range(1)));
            left--;
         end else begin
            sides = $urandom_range(1, 8);
            if ($urandom_range(3) == 0) begin
               lat0 = LAT_W'($urandom);
               lon0 = LON_W'($urandom);
            end else begin
               lat0 = LAT_W'(int'($urandom_range(180000000)) - 90000000);
               lon0 = LON_W'(int'($urandom_range(360000000)) - 180000000);
            end
            lat = lat0;
            lon = lon0;
            for (int k = 0; k < sides && left > 0; k++) begin
               if (k > 0) begin
                  lat = LAT_W'(lat + (int'($urandom_range(2 * span)) - span));
                  lon = LON_W'(lon + (int'($urandom_range(2 * span)) - span));
               end
               // Sometimes the ring is closed explicitly onto its first vertex.
               if (k == sides - 1 && sides > 2 && $urandom_range(3) == 0) begin
                  lat = lat0;
                  lon = lon0;
               end
               send_vertex(lat, lon, k == sides - 1);
               left--;
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part at a zero threshold.
      write_threshold('0);
      // A polygon of a single vertex.
      send_vertex('0, '0, 1'b1);
      // Bit-pattern extremes of both coordinates.
      send_vertex(LAT_TOP, LON_TOP, 1'b0);
      send_vertex(LAT_BOT, LON_BOT, 1'b0);
      send_vertex(LAT_TOP, LON_BOT, 1'b1);
      // Geographic extremes; the last kept vertex equals the first.
      send_vertex(LAT_W'(90000000), LON_W'(180000000), 1'b0);
      send_vertex(LAT_W'(-90000000), LON_W'(-180000000), 1'b0);
      send_vertex(LAT_W'(90000000), LON_W'(180000000), 1'b1);
      // The last vertex repeats the held one and is dropped.
      send_vertex(LAT_W'(1), LON_W'(1), 1'b0);
      send_vertex(LAT_W'(50), LON_W'(50), 1'b0);
      send_vertex(LAT_W'(50), LON_W'(50), 1'b1);

      // A distance equal to the threshold is dropped, one above it is kept.
      write_threshold(THR_W'(25));
      send_vertex('0, '0, 1'b0);
      send_vertex(LAT_W'(3), LON_W'(4), 1'b0);
      send_vertex(LAT_W'(3), LON_W'(5), 1'b1);

      // Largest threshold: only the widest jump gets past it.
      write_threshold('1);
      send_vertex(LAT_BOT, LON_BOT, 1'b0);
      send_vertex(LAT_TOP, LON_TOP, 1'b0);
      send_vertex('0, '0, 1'b1);
      send_vertex(LAT_W'(7), LON_W'(7), 1'b0);
      send_vertex(LAT_W'(8), LON_W'(8), 1'b1);

      // Random part over several thresholds.
      write_threshold('0);
      walk_polygons(PHASE_ITEMS, 2);

      write_threshold(THR_W'($urandom_range(800)));
      calm <= 1'b1;
      walk_polygons(PHASE_ITEMS, 20);

      write_threshold('1);
      calm <= 1'b0;
      walk_polygons(PHASE_ITEMS, 1000);

      write_threshold(THR_W'($urandom_range(1 << 30)));
      walk_polygons(PHASE_ITEMS, 32768);

      write_threshold(THR_W'(3000));
      walk_polygons(PHASE_ITEMS, 40);

      settle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pdd_pkg.sv
rtl/pdd_sq_dist.sv
rtl/pdd_rsp_queue.sv
rtl/polyline_distance_decimator_core.sv
sim/pdd_ring_checker.sv
sim/tb.sv
